@@ rtl/rsrs_pkg.sv @@
// Shared types, constants and the generator step function for the start-slot selector.
`timescale 1ns / 1ps

package rsrs_pkg;

    localparam int MASK_W = 64;
    localparam int SLOT_W = 6;
    localparam int WORD_W = 32;
    localparam int FOLD_W = 16;

    typedef logic [MASK_W-1:0] mask_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [FOLD_W-1:0] fold_t;

    localparam word_t GEN_SEED = 32'd12345;

    // Component constants: pre-shift, arithmetic right shift, keep mask, post-shift
    localparam int unsigned A_PRE  = 6;
    localparam int unsigned A_SH   = 13;
    localparam word_t       A_KEEP = 32'hFFFF_FFFE;
    localparam int unsigned A_POST = 18;

    localparam int unsigned B_PRE  = 2;
    localparam int unsigned B_SH   = 27;
    localparam word_t       B_KEEP = 32'hFFFF_FFF8;
    localparam int unsigned B_POST = 2;

    localparam int unsigned C_PRE  = 13;
    localparam int unsigned C_SH   = 21;
    localparam word_t       C_KEEP = 32'hFFFF_FFF0;
    localparam int unsigned C_POST = 7;

    localparam int unsigned D_PRE  = 3;
    localparam int unsigned D_SH   = 12;
    localparam word_t       D_KEEP = 32'hFFFF_FF80;
    localparam int unsigned D_POST = 13;

    // One Tausworthe component step on a signed 32-bit word
    function automatic word_t taus_step(
        input word_t       z,
        input int unsigned pre,
        input int unsigned sh,
        input word_t       keep,
        input int unsigned post
    );
        word_t mix;
        word_t kept;
        mix  = (z << pre) ^ z;
        mix  = word_t'($signed(mix) >>> sh);
        kept = (z & keep) << post;
        return kept ^ mix;
    endfunction

endpackage

@@ rtl/rsrs_gen.sv @@
// Four-word combined Tausworthe generator state with its next-value mix.
`timescale 1ns / 1ps

module rsrs_gen
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    output rsrs_pkg::word_t     mix_next
);

    rsrs_pkg::word_t a_reg, b_reg, c_reg, d_reg;
    rsrs_pkg::word_t a_next, b_next, c_next, d_next;

    always_comb
    begin
        a_next = rsrs_pkg::taus_step(a_reg, rsrs_pkg::A_PRE, rsrs_pkg::A_SH,
                                     rsrs_pkg::A_KEEP, rsrs_pkg::A_POST);
        b_next = rsrs_pkg::taus_step(b_reg, rsrs_pkg::B_PRE, rsrs_pkg::B_SH,
                                     rsrs_pkg::B_KEEP, rsrs_pkg::B_POST);
        c_next = rsrs_pkg::taus_step(c_reg, rsrs_pkg::C_PRE, rsrs_pkg::C_SH,
                                     rsrs_pkg::C_KEEP, rsrs_pkg::C_POST);
        d_next = rsrs_pkg::taus_step(d_reg, rsrs_pkg::D_PRE, rsrs_pkg::D_SH,
                                     rsrs_pkg::D_KEEP, rsrs_pkg::D_POST);
        mix_next = a_next ^ b_next ^ c_next ^ d_next;
    end

    // Advance once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= rsrs_pkg::GEN_SEED;
            b_reg <= rsrs_pkg::GEN_SEED;
            c_reg <= rsrs_pkg::GEN_SEED;
            d_reg <= rsrs_pkg::GEN_SEED;
        end
        else if (advance)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            d_reg <= d_next;
        end
    end

endmodule

@@ rtl/rsrs_fold.sv @@
// Magnitude of the mixed word folded to a 16-bit value with the same residue mod the slot count.
`timescale 1ns / 1ps

module rsrs_fold
#(
    parameter int PROCESS_SLOTS = 64
)
(
    input  rsrs_pkg::word_t mix,
    output rsrs_pkg::fold_t folded
);

    // Residues of byte weights 2^0, 2^8, 2^16, 2^24
    localparam logic [5:0] R0 = 6'(1 % PROCESS_SLOTS);
    localparam logic [5:0] R1 = 6'(256 % PROCESS_SLOTS);
    localparam logic [5:0] R2 = 6'(65536 % PROCESS_SLOTS);
    localparam logic [5:0] R3 = 6'((2 ** 24) % PROCESS_SLOTS);

    rsrs_pkg::word_t mag;
    logic [13:0]     p0, p1, p2, p3;

    always_comb
    begin
        // Most negative value wraps to 2^31 as an unsigned magnitude
        mag = mix[31] ? (~mix + 32'd1) : mix;
        p0  = 14'(mag[7:0])   * 14'(R0);
        p1  = 14'(mag[15:8])  * 14'(R1);
        p2  = 14'(mag[23:16]) * 14'(R2);
        p3  = 14'(mag[31:24]) * 14'(R3);
        folded = 16'(p0) + 16'(p1) + 16'(p2) + 16'(p3);
    end

endmodule

@@ rtl/rsrs_modn.sv @@
// Remainder of the folded value by the slot count: reciprocal quotient, then subtract and correct.
`timescale 1ns / 1ps

module rsrs_modn
#(
    parameter int PROCESS_SLOTS = 64,
    localparam int SW = $clog2(PROCESS_SLOTS)
)
(
    input  rsrs_pkg::fold_t quo_in,
    output rsrs_pkg::fold_t quo,
    input  rsrs_pkg::fold_t rem_in,
    input  rsrs_pkg::fold_t rem_quo,
    output logic [SW-1:0]   start
);

    localparam int          SHIFT = 22;
    localparam logic [21:0] RECIP = 22'((2 ** SHIFT) / PROCESS_SLOTS);
    localparam rsrs_pkg::fold_t SLOTS_F = 16'(PROCESS_SLOTS);

    logic [37:0]     prod;
    rsrs_pkg::fold_t qn;
    rsrs_pkg::fold_t r;
    rsrs_pkg::fold_t rc;

    // Quotient estimate is exact or one short
    always_comb
    begin
        prod = 38'(quo_in) * 38'(RECIP);
        quo  = prod[37:22];
    end

    always_comb
    begin
        qn    = 16'(rem_quo * SLOTS_F);
        r     = rem_in - qn;
        rc    = (r >= SLOTS_F) ? (r - SLOTS_F) : r;
        start = rc[SW-1:0];
    end

endmodule

@@ rtl/rsrs_pick.sv @@
// First ready slot at or above the start slot, wrapping at the slot count.
`timescale 1ns / 1ps

module rsrs_pick
#(
    parameter int PROCESS_SLOTS = 64,
    localparam int SW = $clog2(PROCESS_SLOTS)
)
(
    input  rsrs_pkg::mask_t ready_mask,
    input  logic [SW-1:0]   start,
    output logic            found,
    output rsrs_pkg::slot_t slot_index
);

    logic [PROCESS_SLOTS-1:0]   live;
    logic [2*PROCESS_SLOTS-1:0] dbl;
    logic [PROCESS_SLOTS-1:0]   rot;
    logic [PROCESS_SLOTS-1:0]   low;
    logic [SW-1:0]              offs;
    logic [SW:0]                sum;
    logic [SW:0]                wrapped;

    always_comb
    begin
        live = ready_mask[PROCESS_SLOTS-1:0];
        dbl  = {live, live};
        rot  = PROCESS_SLOTS'(dbl >> start);
        // Isolate the lowest set bit, then encode its position
        low  = rot & (~rot + PROCESS_SLOTS'(1));
        offs = '0;
        for (int i = 0; i < PROCESS_SLOTS; i++)
        begin
            if (low[i])
            begin
                offs = offs | SW'(i);
            end
        end
        sum     = {1'b0, start} + {1'b0, offs};
        wrapped = (sum >= (SW+1)'(PROCESS_SLOTS)) ? (sum - (SW+1)'(PROCESS_SLOTS)) : sum;
        found   = |live;
        slot_index = '0;
        if (found)
        begin
            slot_index[SW-1:0] = wrapped[SW-1:0];
        end
    end

endmodule

@@ rtl/random_start_ready_selector_core.sv @@
// Top level of the random-start ready-slot selector: pipeline registers and stream handshake.
`timescale 1ns / 1ps

// Channel   Dir  Width   Contents
// s_axis    in   64      tdata[63:0] ready_mask
// m_axis    out  8 + 1   tdata[5:0] slot_index (rest zero), tuser[0] found
//
// Each request transfer advances the generator once and yields one result transfer.
// Five register stages: mixed word, folded magnitude, reciprocal quotient, start slot,
// result. m_axis_tvalid rises when the item is loaded into the result stage; one request
// per cycle is taken while the result side keeps up. A stall on m_axis_tready backs the
// stages up one by one; s_axis_tready drops only when every stage holds an item. Reset
// loads the generator seed and empties all stages.

module random_start_ready_selector_core
#(
    parameter int PROCESS_SLOTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] ready_mask
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [5:0] slot_index, [7:6] zero
    output logic        m_axis_tuser    // [0] found
);

    localparam int SW = $clog2(PROCESS_SLOTS);

    // Stage valids
    logic vld1_reg, vld2_reg, vld3_reg, vld4_reg, vld5_reg;
    logic vld1_next, vld2_next, vld3_next, vld4_next, vld5_next;
    logic en1, en2, en3, en4, en5;

    // Stage payloads
    rsrs_pkg::word_t x_reg;
    rsrs_pkg::mask_t mask1_reg, mask2_reg, mask3_reg, mask4_reg;
    rsrs_pkg::fold_t t2_reg, t3_reg, q3_reg;
    logic [SW-1:0]   start4_reg;
    logic            found_reg;
    rsrs_pkg::slot_t slot_reg;

    rsrs_pkg::word_t mix_next;
    rsrs_pkg::fold_t folded;
    rsrs_pkg::fold_t quo;
    logic [SW-1:0]   start;
    logic            found;
    rsrs_pkg::slot_t slot_index;

    // Load a stage when its feeder holds an item and the stage is free or drains
    always_comb
    begin
        en5 = vld4_reg && (!vld5_reg || m_axis_tready);
        en4 = vld3_reg && (!vld4_reg || en5);
        en3 = vld2_reg && (!vld3_reg || en4);
        en2 = vld1_reg && (!vld2_reg || en3);
        s_axis_tready = !vld1_reg || en2;
        en1 = s_axis_tvalid && s_axis_tready;

        vld1_next = en1 || (vld1_reg && !en2);
        vld2_next = en2 || (vld2_reg && !en3);
        vld3_next = en3 || (vld3_reg && !en4);
        vld4_next = en4 || (vld4_reg && !en5);
        vld5_next = en5 || (vld5_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= vld1_next;
            vld2_reg <= vld2_next;
            vld3_reg <= vld3_next;
            vld4_reg <= vld4_next;
            vld5_reg <= vld5_next;
        end
    end

    // Generator steps on each request transfer; the item uses the new words
    rsrs_gen u_gen
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (en1),
        .mix_next (mix_next)
    );

    rsrs_fold #(.PROCESS_SLOTS(PROCESS_SLOTS)) u_fold
    (
        .mix    (x_reg),
        .folded (folded)
    );

    rsrs_modn #(.PROCESS_SLOTS(PROCESS_SLOTS)) u_modn
    (
        .quo_in  (t2_reg),
        .quo     (quo),
        .rem_in  (t3_reg),
        .rem_quo (q3_reg),
        .start   (start)
    );

    rsrs_pick #(.PROCESS_SLOTS(PROCESS_SLOTS)) u_pick
    (
        .ready_mask (mask4_reg),
        .start      (start4_reg),
        .found      (found),
        .slot_index (slot_index)
    );

    // Payload registers: hold while the stage is not loaded
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            x_reg     <= mix_next;
            mask1_reg <= s_axis_tdata;
        end
        if (en2)
        begin
            t2_reg    <= folded;
            mask2_reg <= mask1_reg;
        end
        if (en3)
        begin
            q3_reg    <= quo;
            t3_reg    <= t2_reg;
            mask3_reg <= mask2_reg;
        end
        if (en4)
        begin
            start4_reg <= start;
            mask4_reg  <= mask3_reg;
        end
        if (en5)
        begin
            found_reg <= found;
            slot_reg  <= slot_index;
        end
    end

    assign m_axis_tvalid = vld5_reg;
    assign m_axis_tdata  = {2'b00, slot_reg};
    assign m_axis_tuser  = found_reg;

endmodule

@@ tb/rsrs_selection_checker.sv @@
// Checker for the start-slot selector: predicts each pick and compares result transfers.
`timescale 1ns / 1ps

module rsrs_selection_checker
#(
    parameter int PROCESS_SLOTS = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    input  logic            s_axis_tready,
    input  rsrs_pkg::mask_t s_axis_tdata,    // [63:0] ready_mask
    input  logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    input  logic [7:0]      m_axis_tdata,    // [5:0] slot_index, [7:6] zero
    input  logic            m_axis_tuser,    // [0] found
    output int              fail_count,
    output int              picks_pending
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic            found;
        rsrs_pkg::slot_t slot;
    } slot_pick_t;

    rsrs_pkg::word_t taus_a;
    rsrs_pkg::word_t taus_b;
    rsrs_pkg::word_t taus_c;
    rsrs_pkg::word_t taus_d;
    slot_pick_t      expected_picks [$];
    int              failures = 0;

    // One combined-Tausworthe component on a signed word; the right shift copies the sign.
    function automatic rsrs_pkg::word_t taus_advance(
        input rsrs_pkg::word_t z,
        input int              pre,
        input int              sh,
        input rsrs_pkg::word_t keep,
        input int              post
    );
        rsrs_pkg::word_t feedback;
        feedback = z ^ (z << pre);
        feedback = (feedback >> sh) | (feedback[31] ? ~(32'hFFFF_FFFF >> sh) : 32'h0);
        return ((z & keep) << post) ^ feedback;
    endfunction

    // Start at |mixed| mod slot count and take the first ready slot going up, with wrap.
    function automatic slot_pick_t pick_ready_slot(input rsrs_pkg::mask_t mask,
                                                   input rsrs_pkg::word_t mixed);
        rsrs_pkg::word_t magnitude;
        int              start;
        int              slot;
        slot_pick_t      pick;
        magnitude = mixed[31] ? (32'h0 - mixed) : mixed;
        start     = int'(magnitude % rsrs_pkg::word_t'(PROCESS_SLOTS));
        pick      = '0;
        for (int i = 0; i < PROCESS_SLOTS; i++)
        begin
            slot = (start + i) % PROCESS_SLOTS;
            if (!pick.found && mask[slot])
            begin
                pick.found = 1'b1;
                pick.slot  = rsrs_pkg::slot_t'(slot);
            end
        end
        return pick;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        slot_pick_t      got;
        slot_pick_t      want;
        rsrs_pkg::word_t next_a;
        rsrs_pkg::word_t next_b;
        rsrs_pkg::word_t next_c;
        rsrs_pkg::word_t next_d;
        if (!rst_n)
        begin
            taus_a = 32'd12345;
            taus_b = 32'd12345;
            taus_c = 32'd12345;
            taus_d = 32'd12345;
            expected_picks.delete();
            picks_pending <= 0;
        end
        else
        begin
            // Check results before queuing this edge's request.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found = m_axis_tuser;
                got.slot  = m_axis_tdata[5:0];
                if (expected_picks.size() == 0)
                begin
                    if (failures < MAX_REPORTS)
                        $display("%0t: unexpected result transfer found=%0b slot=%0d",
                                 $time, got.found, got.slot);
                    failures++;
                end
                else
                begin
                    want = expected_picks.pop_front();
                    if (got != want || m_axis_tdata[7:6] != 2'b00)
                    begin
                        if (failures < MAX_REPORTS)
                            $display({"%0t: mismatch exp found=%0b slot=%0d, ",
                                      "got found=%0b slot=%0d pad=%0b"},
                                     $time, want.found, want.slot, got.found, got.slot,
                                     m_axis_tdata[7:6]);
                        failures++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_a = taus_advance(taus_a, 6, 13, 32'hFFFF_FFFE, 18);
                next_b = taus_advance(taus_b, 2, 27, 32'hFFFF_FFF8, 2);
                next_c = taus_advance(taus_c, 13, 21, 32'hFFFF_FFF0, 7);
                next_d = taus_advance(taus_d, 3, 12, 32'hFFFF_FF80, 13);
                taus_a = next_a;
                taus_b = next_b;
                taus_c = next_c;
                taus_d = next_d;
                expected_picks.push_back(pick_ready_slot(s_axis_tdata,
                                                         next_a ^ next_b ^ next_c ^ next_d));
            end
            picks_pending <= expected_picks.size();
        end
        fail_count <= failures;
    end

endmodule

@@ tb/random_start_ready_selector_core_test.sv @@
// Top of the start-slot selector test: clock, reset, request and result stimulus, verdict.
`timescale 1ns / 1ps

module random_start_ready_selector_core_test;

    localparam int SLOTS        = 64;
    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_TAIL   = 300;     // final stretch runs with no idling on either side
    localparam int DRAIN_CYCLES = 20;      // wait after the last predicted pick before the verdict
    localparam int CYCLE_LIMIT  = 400000;  // cycle count at which a hung run is stopped

    typedef enum int {
        MASK_FULL_RANDOM,
        MASK_SPARSE,
        MASK_EMPTY,
        MASK_ALL_READY,
        MASK_HOLES,
        MASK_RUN
    } mask_shape_e;

    logic            clk           = 1'b0;
    logic            rst_n         = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    rsrs_pkg::mask_t s_axis_tdata  = '0;   // [63:0] ready_mask
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [7:0]      m_axis_tdata;         // [5:0] slot_index, [7:6] zero
    logic            m_axis_tuser;         // [0] found

    int fail_count;
    int picks_pending;
    int cycle_count = 0;
    int gap_pct     = 0;   // chance, in percent, of a sender gap before a request transfer
    int stall_pct   = 0;   // chance, in percent, per cycle of a result-side stall burst

    // Directed requests: empty and full masks, single edge bits, word-boundary bits,
    // alternating and striped patterns; the empty mask is sent twice.
    rsrs_pkg::mask_t directed_masks [20] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
        64'h8000_0000_0000_0001, 64'hAAAA_AAAA_AAAA_AAAA,
        64'h5555_5555_5555_5555, 64'h0000_0000_FFFF_FFFF,
        64'hFFFF_FFFF_0000_0000, 64'h0000_0001_0000_0000,
        64'h0000_0000_8000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFE, 64'h0000_0000_0000_0002,
        64'h4000_0000_0000_0000, 64'h0101_0101_0101_0101,
        64'h8080_8080_8080_8080, 64'h0000_0000_0000_0000,
        64'h0000_0010_0000_0000, 64'hF0F0_F0F0_0F0F_0F0F
    };

    random_start_ready_selector_core #(
        .PROCESS_SLOTS (SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rsrs_selection_checker #(
        .PROCESS_SLOTS (SLOTS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .picks_pending (picks_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stop a hung run: count cycles and give up well past the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: hold tready high, drop it now and then for a burst.
    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Build one ready mask of the given shape.
    function automatic rsrs_pkg::mask_t make_mask(input mask_shape_e shape);
        rsrs_pkg::mask_t m;
        int              lo;
        int              len;
        m = '0;
        case (shape)
            MASK_FULL_RANDOM: m = {$urandom, $urandom};
            MASK_SPARSE:
            begin
                repeat ($urandom_range(1, 3)) m[$urandom_range(0, SLOTS - 1)] = 1'b1;
            end
            MASK_EMPTY:       m = '0;
            MASK_ALL_READY:   m = '1;
            MASK_HOLES:
            begin
                m = '1;
                repeat ($urandom_range(1, 8)) m[$urandom_range(0, SLOTS - 1)] = 1'b0;
            end
            default:
            begin
                // Contiguous run of ready slots, possibly cut off at the top.
                lo  = $urandom_range(0, SLOTS - 1);
                len = $urandom_range(1, 16);
                m   = ((rsrs_pkg::mask_t'(1) << len) - rsrs_pkg::mask_t'(1)) << lo;
            end
        endcase
        return m;
    endfunction

    // Drive one request from a falling edge and hold it until the transfer.
    // Return on the falling edge after the transfer, tvalid still high.
    task automatic send_request(input rsrs_pkg::mask_t mask);
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mask;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int          pick;
        mask_shape_e shape;

        // Hold reset low, then release it on a falling edge.
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under light idling on both sides.
        gap_pct   = 20;
        stall_pct = 20;
        foreach (directed_masks[i])
            send_request(directed_masks[i]);

        // Random part: idling changes every few hundred requests, one segment leans
        // on the result side to back the stages up, the tail runs at full rate.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_TAIL)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else if (n == 800)
            begin
                gap_pct   = 0;
                stall_pct = 75;
            end
            else if (n % 400 == 0)
            begin
                gap_pct   = $urandom_range(0, 40);
                stall_pct = $urandom_range(0, 60);
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                shape = MASK_FULL_RANDOM;
            else if (pick < 60)
                shape = MASK_SPARSE;
            else if (pick < 68)
                shape = MASK_EMPTY;
            else if (pick < 74)
                shape = MASK_ALL_READY;
            else if (pick < 87)
                shape = MASK_HOLES;
            else
                shape = MASK_RUN;
            send_request(make_mask(shape));
        end
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted pick, then let the pipeline settle.
        wait (picks_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && picks_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rsrs_pkg.sv
rtl/rsrs_gen.sv
rtl/rsrs_fold.sv
rtl/rsrs_modn.sv
rtl/rsrs_pick.sv
rtl/random_start_ready_selector_core.sv
tb/rsrs_selection_checker.sv
tb/random_start_ready_selector_core_test.sv
